### rtl/array_linked_list_engine_core_defines.svh
// ----------------------------------------------------------------------------
// array_linked_list_engine_core_defines.svh
// Assertion macros shared by the list engine RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is low
`define ALLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("list engine check failed");
// Clocked check that also holds during reset
`define ALLE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("list engine check failed");
`else
`define ALLE_ASSERT(lbl, clk, rstn, prop)
`define ALLE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/alle_pkg.sv
// ----------------------------------------------------------------------------
// alle_pkg
// Shared widths, defaults and codes of the array linked list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package alle_pkg;

  // Default sizing
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_PUSH_BACK  = 2'd2,
    CMD_ERASE      = 2'd3
  } cmd_e;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_SLOT = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_DUMMY    = 2'd3
  } status_e;

endpackage

`default_nettype wire

### rtl/alle_ram.sv
// ----------------------------------------------------------------------------
// alle_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module alle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port (read returns old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/array_linked_list_engine_core.sv
// ----------------------------------------------------------------------------
// array_linked_list_engine_core
// Fixed-capacity doubly linked list in next/prev/data RAMs with slot 0 as a
// dummy head. Used slots stay packed at 1..count; erase moves the highest
// used slot into the hole and relinks its neighbors.
// ----------------------------------------------------------------------------
//  channel   | signals                                        | direction
//  ----------+------------------------------------------------+----------
//  request   | in_valid_i/in_ready_o, command_i,              | in
//            | slot_position_i, item_value_i                  |
//  response  | out_valid_o/out_ready_i, result_slot_o,        | out
//            | status_o                                       |
//
//  Insert and push step through S_INS_W1 and S_INS_W2; erase through S_ER_W1,
//  plus S_ER_RD2, S_ER_W2 and S_ER_W3 when the highest used slot moves; rejected
//  requests go to S_RESP. Steps are dependent reads then writes on each link RAM.
//  One request is in flight at a time; in_ready_o is low until the response
//  is taken, so a stalled response holds the block.
//  Reset is asynchronous; head links and count clear at once, no RAM sweep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_linked_list_engine_core_defines.svh"

module array_linked_list_engine_core #(
  parameter int unsigned CAPACITY   = alle_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = alle_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [alle_pkg::CMD_W-1:0]    command_i,
  input  logic [alle_pkg::SLOT_W-1:0]   slot_position_i,
  input  logic [alle_pkg::VALUE_W-1:0]  item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [alle_pkg::SLOT_W-1:0]   result_slot_o,
  output logic [alle_pkg::STATUS_W-1:0] status_o
);

  import alle_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int unsigned ExtW = VALUE_W + DATA_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_W1,
    S_INS_W2,
    S_ER_W1,
    S_ER_RD2,
    S_ER_W2,
    S_ER_W3,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       count_q, count_d;
  logic [AW-1:0]       head_next_q, head_next_d;
  logic [AW-1:0]       head_prev_q, head_prev_d;
  logic                rd_head_q, rd_head_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [AW-1:0]       fresh_q, fresh_d;
  logic [AW-1:0]       last_q, last_d;
  logic [AW-1:0]       lp_q, lp_d;
  logic [AW-1:0]       ln_q, ln_d;
  logic [AW-1:0]       res_q, res_d;
  status_e             status_q, status_d;
  logic [DATA_WIDTH-1:0] value_q, value_d;

  // Link and data RAM ports
  logic                  nxt_we, prv_we, dat_we;
  logic [AW-1:0]         nxt_waddr, prv_waddr, dat_waddr;
  logic [AW-1:0]         nxt_wdata, prv_wdata;
  logic [DATA_WIDTH-1:0] dat_wdata;
  logic [AW-1:0]         link_raddr;
  logic [AW-1:0]         nxt_rdata, prv_rdata;
  logic [DATA_WIDTH-1:0] dat_rdata;

  // Decode helpers
  logic [CW-1:0]         pos_ext;
  logic [CW-1:0]         res_ext;
  logic [ExtW-1:0]       value_ext;
  logic                  pos_bad;
  logic                  list_full;
  logic [AW-1:0]         pos_sel;
  logic [AW-1:0]         rd_next;
  logic [AW-1:0]         rd_prev;
  cmd_e                  cmd;

  assign cmd       = cmd_e'(command_i);
  assign pos_ext   = CW'(slot_position_i);
  assign value_ext = ExtW'(item_value_i);
  assign pos_bad   = pos_ext > CW'(count_q);
  assign list_full = count_q == AW'(CAPACITY - 1);

  // Slot 0 links live in registers; RAM reads of slot 0 take them instead
  assign rd_next = rd_head_q ? head_next_q : nxt_rdata;
  assign rd_prev = rd_head_q ? head_prev_q : prv_rdata;

  // Anchor slot for the request
  always_comb begin
    unique case (cmd)
      CMD_PUSH_FRONT: pos_sel = '0;
      CMD_PUSH_BACK:  pos_sel = head_prev_q;
      CMD_INSERT,
      CMD_ERASE:      pos_sel = pos_ext[AW-1:0];
      default:        pos_sel = '0;
    endcase
  end

  // Sequencer: next state, RAM accesses and result
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    fresh_d    = fresh_q;
    last_d     = last_q;
    lp_d       = lp_q;
    ln_d       = ln_q;
    res_d      = res_q;
    status_d   = status_q;
    value_d    = value_q;
    link_raddr = pos_q;
    nxt_we     = 1'b0;
    nxt_waddr  = pos_q;
    nxt_wdata  = fresh_q;
    prv_we     = 1'b0;
    prv_waddr  = fresh_q;
    prv_wdata  = pos_q;
    dat_we     = 1'b0;
    dat_waddr  = fresh_q;
    dat_wdata  = value_q;

    unique case (state_q)
      S_IDLE: begin
        link_raddr = pos_sel;
        if (in_valid_i) begin
          pos_d   = pos_sel;
          fresh_d = count_q + AW'(1);
          last_d  = count_q;
          value_d = value_ext[DATA_WIDTH-1:0];
          res_d   = '0;
          if (cmd == CMD_ERASE) begin
            priority if (pos_bad) begin
              status_d = STAT_BAD_SLOT;
              state_d  = S_RESP;
            end else if (pos_ext == '0) begin
              status_d = STAT_DUMMY;
              state_d  = S_RESP;
            end else begin
              state_d = S_ER_W1;
            end
          end else begin
            priority if (cmd == CMD_INSERT && pos_bad) begin
              status_d = STAT_BAD_SLOT;
              state_d  = S_RESP;
            end else if (list_full) begin
              status_d = STAT_FULL;
              state_d  = S_RESP;
            end else begin
              state_d = S_INS_W1;
            end
          end
        end
      end

      // next[fresh] = after, prev[after] = fresh
      S_INS_W1: begin
        nxt_we    = 1'b1;
        nxt_waddr = fresh_q;
        nxt_wdata = rd_next;
        prv_we    = 1'b1;
        prv_waddr = rd_next;
        prv_wdata = fresh_q;
        state_d   = S_INS_W2;
      end

      // next[pos] = fresh, prev[fresh] = pos, store data
      S_INS_W2: begin
        nxt_we    = 1'b1;
        nxt_waddr = pos_q;
        nxt_wdata = fresh_q;
        prv_we    = 1'b1;
        prv_waddr = fresh_q;
        prv_wdata = pos_q;
        dat_we    = 1'b1;
        dat_waddr = fresh_q;
        dat_wdata = value_q;
        count_d   = count_q + AW'(1);
        res_d     = fresh_q;
        status_d  = STAT_OK;
        state_d   = S_RESP;
      end

      // Unlink the erased slot from its neighbors
      S_ER_W1: begin
        nxt_we    = 1'b1;
        nxt_waddr = rd_prev;
        nxt_wdata = rd_next;
        prv_we    = 1'b1;
        prv_waddr = rd_next;
        prv_wdata = rd_prev;
        res_d     = rd_prev;
        if (last_q != pos_q) begin
          state_d = S_ER_RD2;
        end else begin
          count_d  = count_q - AW'(1);
          status_d = STAT_OK;
          state_d  = S_RESP;
        end
      end

      // Fetch the highest used slot after the unlink has landed
      S_ER_RD2: begin
        link_raddr = last_q;
        state_d    = S_ER_W2;
      end

      // Copy the highest slot into the hole
      S_ER_W2: begin
        nxt_we    = 1'b1;
        nxt_waddr = pos_q;
        nxt_wdata = rd_next;
        prv_we    = 1'b1;
        prv_waddr = pos_q;
        prv_wdata = rd_prev;
        dat_we    = 1'b1;
        dat_waddr = pos_q;
        dat_wdata = dat_rdata;
        lp_d      = rd_prev;
        ln_d      = rd_next;
        if (res_q == last_q) begin
          res_d = pos_q;
        end
        state_d   = S_ER_W3;
      end

      // Point the moved element's neighbors at its new slot
      S_ER_W3: begin
        nxt_we    = 1'b1;
        nxt_waddr = lp_q;
        nxt_wdata = pos_q;
        prv_we    = 1'b1;
        prv_waddr = ln_q;
        prv_wdata = pos_q;
        count_d   = count_q - AW'(1);
        status_d  = STAT_OK;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Head link registers follow writes to slot 0
  always_comb begin
    head_next_d = head_next_q;
    head_prev_d = head_prev_q;
    if (nxt_we && nxt_waddr == '0) begin
      head_next_d = nxt_wdata;
    end
    if (prv_we && prv_waddr == '0) begin
      head_prev_d = prv_wdata;
    end
  end

  assign rd_head_d = link_raddr == '0;

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_next_q <= '0;
      head_prev_q <= '0;
      rd_head_q   <= 1'b0;
      pos_q       <= '0;
      fresh_q     <= '0;
      last_q      <= '0;
      lp_q        <= '0;
      ln_q        <= '0;
      res_q       <= '0;
      status_q    <= STAT_OK;
      value_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_next_q <= head_next_d;
      head_prev_q <= head_prev_d;
      rd_head_q   <= rd_head_d;
      pos_q       <= pos_d;
      fresh_q     <= fresh_d;
      last_q      <= last_d;
      lp_q        <= lp_d;
      ln_q        <= ln_d;
      res_q       <= res_d;
      status_q    <= status_d;
      value_q     <= value_d;
    end
  end

  // Link and data storage
  alle_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (link_raddr),
    .rdata_o (nxt_rdata)
  );

  alle_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (link_raddr),
    .rdata_o (prv_rdata)
  );

  alle_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (dat_waddr),
    .wdata_i (dat_wdata),
    .raddr_i (last_q),
    .rdata_o (dat_rdata)
  );

  // Ports
  assign res_ext       = CW'(res_q);
  assign in_ready_o    = state_q == S_IDLE;
  assign out_valid_o   = state_q == S_RESP;
  assign result_slot_o = res_ext[SLOT_W-1:0];
  assign status_o      = status_q;

  // Checks
  `ALLE_ASSERT_ALWAYS(a_no_overlap, clk_i, !(in_ready_o && out_valid_o))
  `ALLE_ASSERT(a_count_range, clk_i, rst_ni, count_q <= AW'(CAPACITY - 1))
  `ALLE_ASSERT(a_full_status, clk_i, rst_ni, (out_valid_o && status_q == STAT_FULL) |-> list_full)
  `ALLE_ASSERT(a_head_links, clk_i, rst_ni, (state_q == S_IDLE) |-> (head_next_q <= count_q && head_prev_q <= count_q))

endmodule

`default_nettype wire

### bench/array_linked_list_engine_core_tb.sv
// ----------------------------------------------------------------------------
// array_linked_list_engine_core_tb
// Self-checking bench for the array linked list engine. A directed table
// covers reset state, the dummy slot, free slots, pushes on an empty list and
// the moved-predecessor erase. Random phases then grow the list to full and
// shrink it to empty with mostly valid slots plus some noise. Every response is
// checked against a cycle-free list model in the bench or a row's typed values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module array_linked_list_engine_core_tb;
  import alle_pkg::*;

  localparam int unsigned SLOTS = CAPACITY_DEF;

  typedef struct {
    cmd_e             cmd;
    logic [SLOT_W-1:0]  pos;
    logic [VALUE_W-1:0] value;
    bit               typed;
    logic [SLOT_W-1:0]  exp_slot;
    status_e          exp_status;
  } req_row_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    status_e           status;
  } resp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i;
  logic [SLOT_W-1:0]   slot_position_i;
  logic [VALUE_W-1:0]  item_value_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SLOT_W-1:0]   result_slot_o;
  logic [STATUS_W-1:0] status_o;

  // List model state
  logic [SLOT_W-1:0] link_next [SLOTS];
  logic [SLOT_W-1:0] link_prev [SLOTS];
  bit                in_use    [SLOTS];
  logic [SLOT_W-1:0] free_slot;
  int unsigned       used_count;

  resp_t       expected_responses [$];
  req_row_t    directed_rows [$];
  int unsigned error_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned full_peak = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          rx_hold = 0;

  array_linked_list_engine_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .slot_position_i (slot_position_i),
    .item_value_i    (item_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_slot_o   (result_slot_o),
    .status_o        (status_o)
  );

  always #2 clk_i = ~clk_i;

  // Model reset: dummy closes the ring, free slots chained upward
  task automatic list_model_reset();
    for (int i = 0; i < SLOTS; i++) begin
      link_next[i] = (i == 0 || i + 1 >= SLOTS) ? '0 : SLOT_W'(i + 1);
      link_prev[i] = '0;
      in_use[i]    = (i == 0);
    end
    free_slot  = SLOT_W'(1);
    used_count = 0;
  endtask

  // Apply one request to the model, return the response it should produce
  task automatic list_model_step(input cmd_e cmd, input logic [SLOT_W-1:0] pos,
                                 output resp_t resp);
    logic [SLOT_W-1:0] anchor, fresh, pred, succ, top, top_prev, top_next;
    case (cmd)
      CMD_PUSH_FRONT: anchor = '0;
      CMD_PUSH_BACK:  anchor = link_prev[0];
      default:        anchor = pos;
    endcase
    resp.slot = '0;
    if (!in_use[anchor]) begin
      resp.status = STAT_BAD_SLOT;
    end else if (cmd != CMD_ERASE) begin
      if (used_count >= SLOTS - 1 || free_slot == '0) begin
        resp.status = STAT_FULL;
      end else begin
        fresh             = free_slot;
        free_slot         = link_next[fresh];
        succ              = link_next[anchor];
        link_prev[succ]   = fresh;
        link_next[fresh]  = succ;
        link_next[anchor] = fresh;
        link_prev[fresh]  = anchor;
        in_use[fresh]     = 1'b1;
        used_count++;
        resp.slot   = fresh;
        resp.status = STAT_OK;
      end
    end else if (anchor == '0) begin
      resp.status = STAT_DUMMY;
    end else begin
      // unlink, then move the highest used slot into the hole
      pred            = link_prev[anchor];
      succ            = link_next[anchor];
      link_next[pred] = succ;
      link_prev[succ] = pred;
      resp.slot       = pred;
      top             = SLOT_W'(used_count);
      used_count--;
      if (top != anchor) begin
        top_prev            = link_prev[top];
        top_next            = link_next[top];
        link_next[anchor]   = top_next;
        link_prev[anchor]   = top_prev;
        link_next[top_prev] = anchor;
        link_prev[top_next] = anchor;
        if (resp.slot == top) resp.slot = anchor;
      end
      link_next[top] = free_slot;
      link_prev[top] = '0;
      in_use[top]    = 1'b0;
      free_slot      = top;
      resp.status    = STAT_OK;
    end
  endtask

  // Sender gap: mostly none or short, a few long, none in a burst stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (tx_burst || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // Drive one request; returns at the falling edge after it is accepted
  task automatic issue_request(input req_row_t row, input int gap);
    resp_t predicted;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= row.cmd;
    slot_position_i <= row.pos;
    item_value_i    <= row.value;
    do @(posedge clk_i); while (!in_ready_o);
    list_model_step(row.cmd, row.pos, predicted);
    if (row.typed) begin
      predicted.slot   = row.exp_slot;
      predicted.status = row.exp_status;
    end
    expected_responses.push_back(predicted);
    sent_count++;
    if (used_count > full_peak) full_peak = used_count;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding response is back
  task automatic drain_responses();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_responses.size() != 0);
  endtask

  // Random request: mostly valid slots, weighted toward growth or shrink
  function automatic req_row_t random_request(input int grow_pct);
    req_row_t row;
    int r;
    row.value = $urandom;
    row.typed = 1'b0;
    row.exp_slot = '0;
    row.exp_status = STAT_OK;
    r = $urandom_range(99);
    if (r < 10) begin
      row.cmd = cmd_e'($urandom_range(3));
      row.pos = SLOT_W'($urandom_range(SLOTS - 1));
    end else if ($urandom_range(99) < grow_pct) begin
      row.cmd = cmd_e'($urandom_range(2));
      row.pos = SLOT_W'($urandom_range(used_count, 0));
    end else begin
      row.cmd = CMD_ERASE;
      row.pos = (used_count > 0) ? SLOT_W'($urandom_range(used_count, 1))
                                 : SLOT_W'($urandom_range(SLOTS - 1));
    end
    return row;
  endfunction

  // Response pacing with short and long stalls
  always @(negedge clk_i) begin : rx_pace
    int r;
    if ($urandom_range(255) == 0) rx_burst = !rx_burst;
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else begin
      r = $urandom_range(99);
      if (rx_burst || r < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        rx_hold = (r < 95) ? $urandom_range(3) : $urandom_range(40, 8);
        out_ready_i <= 1'b0;
      end
    end
  end

  // Response check against the oldest expectation
  always @(posedge clk_i) begin : resp_check
    resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_responses.size() == 0) begin
        $error("unexpected response: result_slot=%0d status=%0d",
               result_slot_o, status_o);
        error_count++;
      end else begin
        want = expected_responses.pop_front();
        checked_count++;
        status_seen[status_o]++;
        if (result_slot_o !== want.slot) begin
          $error("result_slot: expected %0d, got %0d", want.slot, result_slot_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("array_linked_list_engine_core: mismatch");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    int phase_grow [4];
    int phase_len [4];
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = '0;
    slot_position_i = '0;
    item_value_i    = '0;
    phase_grow = '{50, 85, 15, 50};
    phase_len  = '{300, 200, 200, 150};
    list_model_reset();

    // directed rows; typed expectations only where obvious
    directed_rows.push_back('{CMD_ERASE, 6'd0, 32'h0, 1'b1, 6'd0, STAT_DUMMY});
    directed_rows.push_back('{CMD_ERASE, 6'd1, 32'h0, 1'b1, 6'd0, STAT_BAD_SLOT});
    directed_rows.push_back('{CMD_INSERT, 6'd5, 32'h1, 1'b1, 6'd0, STAT_BAD_SLOT});
    directed_rows.push_back('{CMD_ERASE, 6'd63, 32'h0, 1'b1, 6'd0, STAT_BAD_SLOT});
    directed_rows.push_back('{CMD_PUSH_FRONT, 6'd63, 32'h0, 1'b1, 6'd1, STAT_OK});
    directed_rows.push_back('{CMD_PUSH_FRONT, 6'd0, 32'hFFFF_FFFF, 1'b1, 6'd2, STAT_OK});
    // predecessor of slot 1 is the highest slot, so it moves into the hole
    directed_rows.push_back('{CMD_ERASE, 6'd1, 32'h0, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_PUSH_BACK, 6'd0, 32'h5555_5555, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_INSERT, 6'd0, 32'hAAAA_AAAA, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_INSERT, 6'd2, 32'h0000_FFFF, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_INSERT, 6'd1, 32'hFFFF_0000, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_ERASE, 6'd0, 32'h0, 1'b1, 6'd0, STAT_DUMMY});
    directed_rows.push_back('{CMD_INSERT, 6'd63, 32'h0, 1'b1, 6'd0, STAT_BAD_SLOT});
    directed_rows.push_back('{CMD_ERASE, 6'd5, 32'h0, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_ERASE, 6'd1, 32'h0, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_PUSH_BACK, 6'd21, 32'h1234_5678, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_ERASE, 6'd2, 32'h0, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_ERASE, 6'd1, 32'h0, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_ERASE, 6'd1, 32'h0, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_ERASE, 6'd1, 32'h0, 1'b0, 6'd0, STAT_OK});
    // list is empty again
    directed_rows.push_back('{CMD_ERASE, 6'd1, 32'h0, 1'b1, 6'd0, STAT_BAD_SLOT});
    directed_rows.push_back('{CMD_PUSH_BACK, 6'd42, 32'h8000_0001, 1'b0, 6'd0, STAT_OK});
    directed_rows.push_back('{CMD_ERASE, 6'd42, 32'h0, 1'b1, 6'd0, STAT_BAD_SLOT});

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) issue_request(directed_rows[i], pick_gap());
    drain_responses();

    // random phases: balanced, grow to full, shrink to empty, balanced
    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < phase_len[p]; n++) begin
        if (n % 64 == 0) tx_burst = ($urandom_range(3) == 0);
        issue_request(random_request(phase_grow[p]), pick_gap());
      end
      drain_responses();
    end

    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests, %0d responses, list peaked at %0d of %0d entries",
             sent_count, checked_count, full_peak, SLOTS - 1);
    $display("status seen: ok %0d, bad slot %0d, full %0d, dummy erase %0d",
             status_seen[STAT_OK], status_seen[STAT_BAD_SLOT],
             status_seen[STAT_FULL], status_seen[STAT_DUMMY]);
    if (error_count == 0) begin
      $display("array_linked_list_engine_core: match");
    end else begin
      $display("array_linked_list_engine_core: mismatch");
    end
    $finish;
  end

endmodule
